FILE: rtl/ctf_pkg.sv
package ctf_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanEntries    = 24;
  localparam logic [15:0] GyroWeightRst  = 16'd62915;
  localparam int unsigned DtScale        = 125000;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic        [15:0] interval_us;
  } ctf_in_t;

  typedef struct packed {
    logic signed [15:0] roll_tilt;
    logic signed [15:0] pitch_tilt;
  } ctf_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_ITER, ST_ROUND, ST_MUL1, ST_MUL2, ST_DIV, ST_DONE
  } ctf_state_t;

  typedef struct packed {
    logic load;
    logic pre;
    logic iter;
    logic round;
    logic mul1;
    logic mul2;
    logic div;
  } ctf_cmd_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:  atan_lut = 22'd2949120;
      5'd1:  atan_lut = 22'd1740967;
      5'd2:  atan_lut = 22'd919879;
      5'd3:  atan_lut = 22'd466945;
      5'd4:  atan_lut = 22'd234379;
      5'd5:  atan_lut = 22'd117304;
      5'd6:  atan_lut = 22'd58666;
      5'd7:  atan_lut = 22'd29335;
      5'd8:  atan_lut = 22'd14668;
      5'd9:  atan_lut = 22'd7334;
      5'd10: atan_lut = 22'd3667;
      5'd11: atan_lut = 22'd1833;
      5'd12: atan_lut = 22'd917;
      5'd13: atan_lut = 22'd458;
      5'd14: atan_lut = 22'd229;
      5'd15: atan_lut = 22'd115;
      5'd16: atan_lut = 22'd57;
      5'd17: atan_lut = 22'd29;
      5'd18: atan_lut = 22'd14;
      5'd19: atan_lut = 22'd7;
      5'd20: atan_lut = 22'd4;
      5'd21: atan_lut = 22'd2;
      5'd22: atan_lut = 22'd1;
      default: atan_lut = 22'd0;
    endcase
  endfunction

endpackage

FILE: rtl/ctf_ctrl.sv
module ctf_ctrl
  import ctf_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     out_taken,
  output logic     busy,
  output logic     done,
  output logic [4:0] step,
  output ctf_cmd_t cmd
);

  localparam int unsigned Steps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

  ctf_state_t state_r, state_nxt;
  logic [4:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_PRE;
      ST_PRE: begin
        state_nxt = ST_ITER;
        step_nxt  = '0;
      end
      ST_ITER: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'(Steps - 1)) state_nxt = ST_ROUND;
      end
      ST_ROUND: state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_DONE;
      ST_DONE:  if (out_taken) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.load  = (state_r == ST_IDLE) && start;
    cmd.pre   = (state_r == ST_PRE);
    cmd.iter  = (state_r == ST_ITER);
    cmd.round = (state_r == ST_ROUND);
    cmd.mul1  = (state_r == ST_MUL1);
    cmd.mul2  = (state_r == ST_MUL2);
    cmd.div   = (state_r == ST_DIV);
    busy      = (state_r != ST_IDLE);
    done      = (state_r == ST_DONE);
    step      = step_r;
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ITER |-> step_r < 5'(Steps)) else $error("step overrun");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_PRE) else $error("load lost");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_taken) |=> state_r == ST_DONE) else $error("done dropped");

endmodule

FILE: rtl/ctf_dp.sv
module ctf_dp
  import ctf_pkg::*;
(
  input  logic        clk,
  input  ctf_cmd_t    cmd,
  input  logic [4:0]  step,
  input  ctf_in_t     in_word,
  input  logic [15:0] weight,
  input  logic        rst_n,
  output ctf_out_t    result
);

  localparam logic signed [49:0] HalfDen = 50'sd4096000000;  // 65536*125000/2
  localparam logic signed [49:0] SatSpan = 50'sd4096000000;  // 32768*125000
  localparam logic [30:0]        RecipM  = 31'd1125899907;   // ceil(2^44/15625)

  // CORDIC lanes: roll (0) and pitch (1); values scaled by 256, 27 bits ample
  logic signed [26:0] x_r [2];
  logic signed [26:0] y_r [2];
  logic signed [25:0] z_r [2];
  logic               zero_r [2];
  logic signed [15:0] acc_r [2];
  logic signed [15:0] est_r [2];
  logic signed [15:0] rate_r [2];
  logic        [15:0] dt_r;
  logic signed [34:0] pred_r [2];
  logic signed [49:0] pa_r [2];
  logic signed [49:0] pb_r [2];
  logic        [29:0] v_r [2];
  logic               hi_r [2];
  logic               lo_r [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [26:0] xs, ys;
    logic signed [25:0] zr;
    logic signed [17:0] wgt;
    logic signed [17:0] cwt;
    logic signed [33:0] wa;
    logic signed [49:0] num;
    logic signed [49:0] q;
    logic signed [49:0] u;
    logic        [60:0] prod;
    logic        [15:0] qt;

    assign xs  = x_r[l] >>> step;
    assign ys  = y_r[l] >>> step;
    assign zr  = (z_r[l] + 26'sd256) >>> 9;
    assign wgt = $signed({2'b00, weight});
    assign cwt = 18'sd65536 - wgt;
    assign wa  = 34'(cwt) * 34'(acc_r[l]);
    assign num = pa_r[l] + pb_r[l] + HalfDen;
    // floor divide by 65536*125000: shift out 2^16, then floor by 125000
    assign q   = num >>> 16;
    // offset into [0, 65536*125000) so the quotient is unsigned
    assign u   = q + SatSpan;
    // u/125000 = (u>>3)/15625, exact by reciprocal for 30-bit operands
    assign prod = 61'(v_r[l]) * 61'(RecipM);
    assign qt   = prod[59:44];

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        x_r[l]  <= 27'(in_word.accel_z) <<< 8;
        y_r[l]  <= (l == 0) ? (27'(in_word.accel_y) <<< 8) : -(27'(in_word.accel_x) <<< 8);
        z_r[l]  <= '0;
        rate_r[l] <= (l == 0) ? in_word.rate_x : in_word.rate_y;
        zero_r[l] <= (in_word.accel_z == 0) &&
                     ((l == 0) ? (in_word.accel_y == 0) : (in_word.accel_x == 0));
      end else if (cmd.pre) begin
        if (x_r[l] < 0) begin
          if (y_r[l] >= 0) begin
            x_r[l] <= y_r[l];
            y_r[l] <= -x_r[l];
            z_r[l] <= 26'sd5898240;
          end else begin
            x_r[l] <= -y_r[l];
            y_r[l] <= x_r[l];
            z_r[l] <= -26'sd5898240;
          end
        end
      end else if (cmd.iter) begin
        if (y_r[l] >= 0) begin
          x_r[l] <= x_r[l] + ys;
          y_r[l] <= y_r[l] - xs;
          z_r[l] <= z_r[l] + $signed({4'd0, atan_lut(step)});
        end else begin
          x_r[l] <= x_r[l] - ys;
          y_r[l] <= y_r[l] + xs;
          z_r[l] <= z_r[l] - $signed({4'd0, atan_lut(step)});
        end
      end
      if (cmd.round) begin
        acc_r[l]  <= zero_r[l] ? 16'sd0 : 16'(zr);
        pred_r[l] <= 35'(est_r[l]) * 35'sd125000 + 35'(rate_r[l]) * $signed({19'd0, dt_r});
      end
      if (cmd.mul1) begin
        pa_r[l] <= 50'(wgt) * 50'(pred_r[l]);
        pb_r[l] <= 50'(wa) * 50'sd125000;
      end
      if (cmd.mul2) begin
        hi_r[l] <= (q >= SatSpan);
        lo_r[l] <= (q < -SatSpan);
        v_r[l]  <= u[32:3];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) est_r[l] <= '0;
      else if (cmd.div) begin
        if (hi_r[l]) est_r[l] <= 16'sh7FFF;
        else if (lo_r[l]) est_r[l] <= 16'sh8000;
        else est_r[l] <= $signed({~qt[15], qt[14:0]});
      end
    end
  end

  always_ff @(posedge clk) if (cmd.load) dt_r <= in_word.interval_us;

  assign result.roll_tilt  = est_r[0];
  assign result.pitch_tilt = est_r[1];

endmodule

FILE: rtl/complementary_tilt_filter_top.sv
// Each word is accepted, then steps through ST_PRE, CORDIC_STEPS (clamped to
// 24) ST_ITER steps, ST_ROUND, ST_MUL1, ST_MUL2, ST_DIV and ST_DONE, where the
// result waits until taken; no new word is accepted before then, so a held result
// stalls the input. Roll and pitch run side by side in two iterative CORDIC lanes.
// Reset (rst_n low, synchronous): roll/pitch estimates clear to zero,
// gyro_weight returns to 62915, controller returns to idle.
module complementary_tilt_filter_top
  import ctf_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ctf_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ctf_out_t    out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] weight_r;
  logic        busy, done;
  logic [4:0]  step;
  ctf_cmd_t    cmd;

  // Register file: only gyro_weight at address 0; others ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) weight_r <= GyroWeightRst;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      weight_r <= cfg_pwdata[15:0];
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'd0, weight_r} : 32'd0;

  // Accept a word only when idle; result register holds until taken.
  assign in_ready  = !busy;
  assign out_valid = done;

  ctf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n,
    .start(in_valid),
    .out_taken(out_ready),
    .busy, .done, .step, .cmd
  );

  ctf_dp u_dp (
    .clk, .rst_n, .cmd, .step,
    .in_word(in_data),
    .weight(weight_r),
    .result(out_data)
  );

endmodule

FILE: tb/complementary_tilt_filter_top_test.sv
// Self-checking bench for the roll/pitch complementary filter.
// Every accepted sample runs through a local fixed-point model of the
// CORDIC tilt and the gyro/accel blend. The expected angles wait in a queue,
// and each output word is compared against the oldest one.
module complementary_tilt_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctf_pkg::*;

  localparam logic [1:0] GyroWeightAddr = 2'd0;
  localparam int unsigned TiltSteps = (CordicStepsDef > AtanEntries) ? AtanEntries
                                                                     : CordicStepsDef;
  // leave generous slack beyond the accept-to-result time
  localparam int unsigned SettleCycles = 3 * (TiltSteps + 7);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ctf_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ctf_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // local copy of the filter state and its one register
  logic [15:0]        gyro_weight_q = GyroWeightRst;
  logic signed [15:0] roll_est_q = '0;
  logic signed [15:0] pitch_est_q = '0;

  ctf_out_t pending_angles_q[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_off_cycles = 0;

  complementary_tilt_filter_top dut (.*);

  always #5 clk = ~clk;

  // atan2 in 1/128 degree, built like the hardware's vectoring CORDIC
  function automatic logic signed [15:0] tilt_atan2(longint y, longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return '0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < TiltSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_lut(5'(i)));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_lut(5'(i)));
      end
    end
    return 16'((z + 256) >>> 9);
  endfunction

  // weighted blend of integrated gyro and accel angle, round half up, saturate
  function automatic logic signed [15:0] fuse_angle(longint est, longint rate,
                                                     longint dt, longint acc);
    longint w;
    longint den;
    longint num;
    longint q;
    w   = longint'(gyro_weight_q);
    den = 64'd65536 * DtScale;
    num = w * (est * DtScale + rate * dt) + (65536 - w) * acc * DtScale + den / 2;
    q   = (num < 0) ? -((-num + den - 1) / den) : num / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic void advance_filter(ctf_in_t s);
    ctf_out_t r;
    r.roll_tilt  = fuse_angle(roll_est_q, s.rate_x, s.interval_us,
                              tilt_atan2(s.accel_y, s.accel_z));
    r.pitch_tilt = fuse_angle(pitch_est_q, s.rate_y, s.interval_us,
                              tilt_atan2(-longint'(s.accel_x), s.accel_z));
    roll_est_q  = r.roll_tilt;
    pitch_est_q = r.pitch_tilt;
    pending_angles_q.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Receiver: a long hold-off wins, otherwise stall at the phase's rate.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each delivered word with the oldest expectation.
  always @(posedge clk) begin
    ctf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_angles_q.size() == 0) begin
        report_mismatch("unexpected word roll", out_data.roll_tilt, 0);
      end else begin
        want = pending_angles_q.pop_front();
        if (out_data.roll_tilt !== want.roll_tilt)
          report_mismatch("roll_tilt", out_data.roll_tilt, want.roll_tilt);
        if (out_data.pitch_tilt !== want.pitch_tilt)
          report_mismatch("pitch_tilt", out_data.pitch_tilt, want.pitch_tilt);
      end
    end
  end

  // Offer one sample, maybe after an idle gap; return at the accepting edge.
  task automatic send_sample(ctf_in_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
    advance_filter(s);
  endtask

  task automatic drain_filter();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_angles_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write in setup and access phases; only called with the filter idle.
  task automatic write_gyro_weight(logic [15:0] w);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= GyroWeightAddr; cfg_pwdata <= {16'($urandom_range(65535)), w};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    gyro_weight_q = w;
  endtask

  function automatic ctf_in_t make_sample(int ax, int ay, int az, int rx, int ry, int dt);
    ctf_in_t s;
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    s.rate_x = 16'(rx); s.rate_y = 16'(ry); s.interval_us = 16'(dt);
    return s;
  endfunction

  // Mostly plausible level-flight samples, some fully random words.
  function automatic ctf_in_t random_sample();
    ctf_in_t s;
    if ($urandom_range(99) < 25) return ctf_in_t'({$urandom, $urandom, $urandom});
    s = make_sample($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                    16384 + $urandom_range(4000) - 2000,
                    $urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                    $urandom_range(4000, 6000));
    if ($urandom_range(9) == 0) s.accel_z = -s.accel_z;  // upside down
    return s;
  endfunction

  // Field extremes and each corner of the atan2 and blend.
  task automatic test_corners();
    send_sample(make_sample(0, 0, 0, 0, 0, 5000));              // both operands zero
    send_sample(make_sample(0, 0, -16384, 0, 0, 0));            // flip: +180
    send_sample(make_sample(1000, -1000, -16384, 0, 0, 0));     // x negative, y negative
    send_sample(make_sample(-1000, 1000, -16384, 0, 0, 0));     // x negative, y positive
    send_sample(make_sample(-32768, 32767, 0, 0, 0, 0));        // x zero
    send_sample(make_sample(32767, -32768, -32768, 0, 0, 65535));
    send_sample(make_sample(-32768, -32768, 32767, 32767, -32768, 65535));
    send_sample(make_sample(32767, 32767, 32767, -32768, 32767, 65535));
    send_sample(make_sample(1, -1, 1, 1, -1, 1));
    send_sample(make_sample(0, 16384, 0, 100, -100, 0));        // zero interval
    drain_filter();
    // Near-pure gyro path (weight 0xFFFF) with max rate and interval: drive both estimates into saturation.
    write_gyro_weight(16'hFFFF);
    repeat (6) send_sample(make_sample(0, 0, 16384, 32767, -32768, 65535));
    repeat (6) send_sample(make_sample(0, 0, 16384, -32768, 32767, 65535));
    drain_filter();
    write_gyro_weight(16'h0000);                                // pure accel path
    send_sample(make_sample(-20000, 20000, -5, 32767, 32767, 65535));
    send_sample(make_sample(20000, -20000, 5, 0, 0, 100));
    drain_filter();
  endtask

  // Random samples under one weight and one pair of idle rates.
  task automatic test_random_phase(logic [15:0] w, int snd, int rcv, int n);
    write_gyro_weight(w);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    repeat (n) send_sample(random_sample());
    drain_filter();
  endtask

  // Hold the output off while samples keep coming, so the input stalls,
  // then pause the sender until every word has come back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 300;
    repeat (20) send_sample(random_sample());
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_angles_q.size() != 0) @(posedge clk);
    repeat (20) send_sample(random_sample());
    drain_filter();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random_phase(GyroWeightRst, 29, 77, 160);
    test_random_phase(16'($urandom_range(65535)), 77, 29, 160);
    test_random_phase(16'hFFFF, 0, 0, 60);
    test_random_phase(16'h0000, 0, 0, 60);
    test_backpressure();
    if (mismatches == 0) begin
      $display("PASS complementary_tilt_filter_top");
    end else begin
      $display("FAIL complementary_tilt_filter_top");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL complementary_tilt_filter_top");
    $finish;
  end

endmodule
